FILE: rtl/cbec_pkg.sv
// Shared types, constants and helper functions of the control byte escape codec.
// No dependencies; every other file refers to it by scoped names.
package cbec_pkg;

   localparam logic [7:0] ESC_BYTE = 8'h1b;
   localparam logic [7:0] STX_BYTE = 8'h02;
   localparam logic [7:0] XON_BYTE = 8'h11;
   localparam logic [7:0] XOF_BYTE = 8'h13;

   localparam logic [1:0] STOP_NONE    = 2'd0;
   localparam logic [1:0] STOP_RAW     = 2'd1;
   localparam logic [1:0] STOP_ESCAPED = 2'd2;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0]  REG_DECODE_MODE  = 1'b0;
   localparam logic [0:0]  REG_STRICT_CHECK = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
      logic [1:0] stop_cause;
   } rsp_type;

   typedef struct packed {
      logic decode_mode;
      logic strict_check;
   } cfg_type;

   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } eng_out_type;

   function automatic logic is_control(input logic [7:0] b);
      logic hit;
      unique case (b)
         8'h02, 8'h03, 8'h05, 8'h06, 8'h11,
         8'h13, 8'h15, 8'h17, 8'h1b: hit = 1'b1;
         default:                    hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_raw_halt(input logic [7:0] b, input logic strict);
      logic hit;
      if (strict) begin
         hit = is_control(b) && (b != ESC_BYTE);
      end else begin
         hit = (b == STX_BYTE) || (b == XON_BYTE) || (b == XOF_BYTE);
      end
      return hit;
   endfunction

endpackage

FILE: rtl/cbec_csr.sv
// APB-style configuration registers of the escape codec: mode and strict check.
// Depends on cbec_pkg.
module cbec_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cbec_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output cbec_pkg::cfg_type                cfg
);

   cbec_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [0:0]        reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            cbec_pkg::REG_DECODE_MODE:  cfg_in.decode_mode  = csr_pwdata[0];
            cbec_pkg::REG_STRICT_CHECK: cfg_in.strict_check = csr_pwdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         cbec_pkg::REG_DECODE_MODE:  csr_prdata = {31'd0, cfg_ff.decode_mode};
         cbec_pkg::REG_STRICT_CHECK: csr_prdata = {31'd0, cfg_ff.strict_check};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/cbec_engine.sv
// Escape and unescape logic with the per-buffer decode state.
// Depends on cbec_pkg; produces up to two results per accepted transaction.
module cbec_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  cbec_pkg::cfg_type     cfg,
   input  logic                  accept,
   input  cbec_pkg::req_type     req,
   output cbec_pkg::eng_out_type eng
);

   logic       esc_pending_ff, esc_pending_in;
   logic [1:0] halt_ff, halt_in;
   logic [7:0] b;
   logic [7:0] inv_b;
   logic       last;

   cbec_pkg::eng_out_type res;

   assign b     = req.in_byte;
   assign inv_b = ~req.in_byte;
   assign last  = req.in_last;

   always_comb begin
      res            = '0;
      esc_pending_in = esc_pending_ff;
      halt_in        = halt_ff;
      if (!cfg.decode_mode) begin
         if (cbec_pkg::is_control(b)) begin
            res.first_valid  = 1'b1;
            res.first        = '{cbec_pkg::ESC_BYTE, 1'b1, 1'b0, cbec_pkg::STOP_NONE};
            res.second_valid = 1'b1;
            res.second       = '{inv_b, 1'b1, last, cbec_pkg::STOP_NONE};
         end else begin
            res.first_valid  = 1'b1;
            res.first        = '{b, 1'b1, last, cbec_pkg::STOP_NONE};
         end
      end else begin
         priority if (halt_ff != cbec_pkg::STOP_NONE) begin
            res.first_valid = 1'b1;
            res.first       = '{b, 1'b1, last, halt_ff};
         end else if (esc_pending_ff) begin
            esc_pending_in = 1'b0;
            if (cfg.strict_check && !cbec_pkg::is_control(inv_b)) begin
               halt_in = cbec_pkg::STOP_ESCAPED;
            end
            res.first_valid = 1'b1;
            res.first       = '{inv_b, 1'b1, last, halt_in};
         end else if (cbec_pkg::is_raw_halt(b, cfg.strict_check)) begin
            halt_in         = cbec_pkg::STOP_RAW;
            res.first_valid = 1'b1;
            res.first       = '{b, 1'b1, last, cbec_pkg::STOP_RAW};
         end else if (b == cbec_pkg::ESC_BYTE) begin
            esc_pending_in = 1'b1;
            if (last) begin
               res.first_valid = 1'b1;
               res.first       = '{8'd0, 1'b0, 1'b1, cbec_pkg::STOP_NONE};
            end
         end else begin
            res.first_valid = 1'b1;
            res.first       = '{b, 1'b1, last, cbec_pkg::STOP_NONE};
         end
      end
      if (last) begin
         esc_pending_in = 1'b0;
         halt_in        = cbec_pkg::STOP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_pending_ff <= 1'b0;
         halt_ff        <= cbec_pkg::STOP_NONE;
      end else if (accept) begin
         esc_pending_ff <= esc_pending_in;
         halt_ff        <= halt_in;
      end
   end

   always_comb begin
      eng              = res;
      eng.first_valid  = res.first_valid && accept;
      eng.second_valid = res.second_valid && accept;
   end

   a_esc_halt_excl: assert property (@(posedge clock) disable iff (reset)
      !(esc_pending_ff && (halt_ff != cbec_pkg::STOP_NONE)))
      else $error("escape pending while halted");

   a_halt_code: assert property (@(posedge clock) disable iff (reset)
      halt_ff != 2'd3)
      else $error("halt status holds an undefined cause");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.in_last) |=> (!esc_pending_ff && (halt_ff == cbec_pkg::STOP_NONE)))
      else $error("state not cleared after end of buffer");

endmodule

FILE: rtl/cbec_out_buf.sv
// Result register with a second holding slot for the escaped byte of a pair.
// Depends on cbec_pkg; drives the input ready from its occupancy.
module cbec_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  cbec_pkg::eng_out_type eng,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cbec_pkg::rsp_type     rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   cbec_pkg::rsp_type rsp_data_ff, rsp_data_in;
   cbec_pkg::rsp_type pend_data_ff, pend_data_in;

   assign req_ready = !pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      priority if (pend_valid_ff) begin
         if (rsp_ready) begin
            rsp_data_in   = pend_data_ff;
            pend_valid_in = 1'b0;
         end
      end else if (eng.first_valid) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = eng.first;
         pend_valid_in = eng.second_valid;
         pend_data_in  = eng.second;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pend_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("second byte held without a first");

   a_pend_blocks_input: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !req_ready)
      else $error("input taken while second byte still held");

   a_pend_promotes: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && rsp_ready) |=> (rsp_valid_ff && !pend_valid_ff))
      else $error("held second byte not advanced");

endmodule

FILE: rtl/control_byte_escape_codec_core.sv
// Control byte escape codec, top level: configuration registers, codec engine, result buffer.
// The first result of a transaction is written into the result register when the transaction is accepted.
// Throughput: one byte per cycle while the receiver takes results; for an escaped control byte in encode mode,
// the second result waits in the holding slot of the result buffer while input stalls.
// Reset (synchronous): encode mode, strict check off, no escape pending, not halted, buffer empty.
module control_byte_escape_codec_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cbec_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cbec_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cbec_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   cbec_pkg::cfg_type     cfg;
   cbec_pkg::eng_out_type eng;
   logic                  accept;

   assign accept = req_valid && req_ready;

   cbec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbec_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (accept),
      .req    (req_data),
      .eng    (eng)
   );

   cbec_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .eng       (eng),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/testbench.sv
// Self-checking bench for control_byte_escape_codec_core: encode, decode and strict decode runs.
// Drives the block through valid/ready and the APB-style register port; needs cbec_pkg only.
// A scoreboard class predicts every result from the accepted bytes and checks them in order.
module testbench;

   class escape_scoreboard;
      bit                    decode_mode;
      bit                    strict_check;
      bit                    escape_pending;
      logic [1:0]            halt_status;
      cbec_pkg::rsp_type     predicted[$];
      int                    errors;

      function void clear_state();
         decode_mode    = 1'b0;
         strict_check   = 1'b0;
         escape_pending = 1'b0;
         halt_status    = cbec_pkg::STOP_NONE;
         predicted.delete();
      endfunction

      function void set_register(logic [0:0] index, bit value);
         if (index == cbec_pkg::REG_DECODE_MODE) begin
            decode_mode = value;
         end else begin
            strict_check = value;
         end
      endfunction

      function bit control_code(logic [7:0] b);
         return b == 8'h02 || b == 8'h03 || b == 8'h05 || b == 8'h06 || b == 8'h11 ||
                b == 8'h13 || b == 8'h15 || b == 8'h17 || b == cbec_pkg::ESC_BYTE;
      endfunction

      function bit halts_raw(logic [7:0] b);
         if (strict_check) begin
            return control_code(b) && b != cbec_pkg::ESC_BYTE;
         end
         return b == cbec_pkg::STX_BYTE || b == cbec_pkg::XON_BYTE || b == cbec_pkg::XOF_BYTE;
      endfunction

      function void add(logic [7:0] b, logic has, logic last, logic [1:0] cause);
         cbec_pkg::rsp_type r;
         r.out_byte   = b;
         r.has_byte   = has;
         r.out_last   = last;
         r.stop_cause = cause;
         predicted.push_back(r);
      endfunction

      function void note_byte(cbec_pkg::req_type item);
         logic [7:0] b;
         logic       last;
         logic [7:0] restored;
         b    = item.in_byte;
         last = item.in_last;
         if (!decode_mode) begin
            if (control_code(b)) begin
               add(cbec_pkg::ESC_BYTE, 1'b1, 1'b0, cbec_pkg::STOP_NONE);
               add(~b, 1'b1, last, cbec_pkg::STOP_NONE);
            end else begin
               add(b, 1'b1, last, cbec_pkg::STOP_NONE);
            end
         end else if (halt_status != cbec_pkg::STOP_NONE) begin
            add(b, 1'b1, last, halt_status);
         end else if (escape_pending) begin
            restored       = ~b;
            escape_pending = 1'b0;
            if (strict_check && !control_code(restored)) begin
               halt_status = cbec_pkg::STOP_ESCAPED;
            end
            add(restored, 1'b1, last, halt_status);
         end else if (halts_raw(b)) begin
            halt_status = cbec_pkg::STOP_RAW;
            add(b, 1'b1, last, halt_status);
         end else if (b == cbec_pkg::ESC_BYTE) begin
            escape_pending = 1'b1;
            if (last) begin
               add(8'h00, 1'b0, 1'b1, cbec_pkg::STOP_NONE);
            end
         end else begin
            add(b, 1'b1, last, cbec_pkg::STOP_NONE);
         end
         if (last) begin
            escape_pending = 1'b0;
            halt_status    = cbec_pkg::STOP_NONE;
         end
      endfunction

      function void check_output(cbec_pkg::rsp_type actual);
         cbec_pkg::rsp_type want;
         if (predicted.size() == 0) begin
            $display("%0t unexpected output: expected none, actual byte %h has %b last %b cause %0d",
                     $time, actual.out_byte, actual.has_byte, actual.out_last,
                     actual.stop_cause);
            errors++;
            return;
         end
         want = predicted.pop_front();
         if (actual.out_byte !== want.out_byte || actual.has_byte !== want.has_byte ||
             actual.out_last !== want.out_last || actual.stop_cause !== want.stop_cause) begin
            $display("%0t output mismatch: expected byte %h has %b last %b cause %0d,",
                     $time, want.out_byte, want.has_byte, want.out_last, want.stop_cause,
                     " actual byte %h has %b last %b cause %0d",
                     actual.out_byte, actual.has_byte, actual.out_last, actual.stop_cause);
            errors++;
         end
      endfunction

      function int outstanding();
         return predicted.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   cbec_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   cbec_pkg::rsp_type               rsp_data;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [cbec_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   escape_scoreboard board = new;
   int                sender_pct;
   int                stall_pct = 0;
   int                hold_kick = 0;
   int                hold_seen = 0;
   int                hold_left = 0;
   logic [7:0]        ctl_codes [9] = '{8'h02, 8'h03, 8'h05, 8'h06, 8'h11,
                                        8'h13, 8'h15, 8'h17, 8'h1b};

   control_byte_escape_codec_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= 60;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_output(rsp_data);
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last);
      cbec_pkg::req_type item;
      int                gap;
      item.in_byte = b;
      item.in_last = last;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_pct) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_byte(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [0:0] index, input bit value);
      logic [31:0] word;
      word    = $urandom();
      word[0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      board.set_register(index, value);
   endtask

   task automatic set_mode(input bit decode, input bit strict);
      drain();
      write_register(cbec_pkg::REG_DECODE_MODE, decode);
      write_register(cbec_pkg::REG_STRICT_CHECK, strict);
   endtask

   task automatic run_phase(input bit decode, input bit strict, input int count,
                            input int spct, input int rpct, input bit pressure);
      logic [7:0] buffer[$];
      logic [7:0] b;
      int         sent;
      int         len;
      int         pick;
      bit         well_formed;
      bit         close;
      set_mode(decode, strict);
      sender_pct = spct;
      stall_pct <= rpct;
      if (pressure) begin
         hold_kick <= hold_kick + 1;
      end
      sent = 0;
      while (sent < count) begin
         buffer.delete();
         len         = $urandom_range(1, 10);
         well_formed = ($urandom_range(99) < 75);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
               b = ctl_codes[$urandom_range(8)];
            end else if (pick < 40) begin
               b = 8'h00;
            end else if (pick < 45) begin
               b = 8'hff;
            end else begin
               b = 8'($urandom_range(255));
            end
            if (decode && well_formed && board.control_code(b)) begin
               buffer.push_back(cbec_pkg::ESC_BYTE);
               buffer.push_back(~b);
            end else begin
               buffer.push_back(b);
            end
         end
         if (decode && $urandom_range(9) == 0) begin
            buffer.push_back(cbec_pkg::ESC_BYTE);
         end
         close = ($urandom_range(9) != 0);
         foreach (buffer[i]) begin
            send_byte(buffer[i], close && i == buffer.size() - 1);
            sent++;
            if (pressure && sent == count / 2) begin
               drain();
            end
         end
      end
   endtask

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int  k;
      int  spct;
      int  rpct;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      sender_pct  = 0;
      board.clear_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // encode: extremes, escaped pair with and without last
      set_mode(1'b0, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h1b, 1'b0);
      send_byte(8'h17, 1'b1);
      send_byte(8'h7f, 1'b1);

      // decode: restored bytes, raw halts, trailing escape
      set_mode(1'b1, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h1b, 1'b0);
      send_byte(8'hfd, 1'b0);
      send_byte(8'h1b, 1'b0);
      send_byte(8'he4, 1'b1);
      send_byte(8'h02, 1'b0);
      send_byte(8'h1b, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h11, 1'b0);
      send_byte(8'h13, 1'b1);
      send_byte(8'h1b, 1'b1);
      send_byte(8'h1b, 1'b0);

      // switch mode with an escape pending, then resume decoding strictly
      set_mode(1'b0, 1'b1);
      send_byte(8'h55, 1'b0);
      set_mode(1'b1, 1'b1);
      send_byte(8'hfa, 1'b0);
      send_byte(8'h1b, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h13, 1'b1);
      send_byte(8'h05, 1'b0);
      send_byte(8'h30, 1'b1);

      for (int p = 0; p < 8; p++) begin
         k    = (p + p / 4) % 4;
         spct = (p / 2 == 1) ? 52 : (p / 2 == 3) ? 10 : 0;
         rpct = (p / 2 == 2) ? 52 : (p / 2 == 3) ? 10 : 0;
         run_phase(k == 1 || k == 2, k >= 2, 135, spct, rpct, p == 1 || p == 5);
      end

      sender_pct = 0;
      stall_pct <= 0;
      drain();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
